[rtl/core/hst_pkg.sv]
// Shared types, constants and score helpers for the hashed score table.
`default_nettype none

package hst_pkg;

    // Table depth must be a power of two; the slot is the low key bits.
    localparam int TABLE_ENTRIES = 4096;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);

    localparam int KEY_W     = 64;
    localparam int DEPTH_W   = 8;
    localparam int SCORE_W   = 18;
    localparam int BOUND_W   = 2;
    localparam int MOVE_W    = 16;
    localparam int PLY_W     = 8;
    localparam int STATUS_W  = 2;
    localparam int S_TDATA_W = 152;
    localparam int M_TDATA_W = 40;

    typedef logic signed [SCORE_W-1:0] score_t;
    typedef logic signed [SCORE_W:0]   score_wide_t;

    typedef enum logic [0:0] {
        REQ_STORE = 1'b0,
        REQ_PROBE = 1'b1
    } req_t;

    localparam logic [BOUND_W-1:0] BOUND_EXACT = 2'd0;
    localparam logic [BOUND_W-1:0] BOUND_UPPER = 2'd1;
    localparam logic [BOUND_W-1:0] BOUND_LOWER = 2'd2;

    localparam logic [STATUS_W-1:0] ST_USABLE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SHALLOW = 2'd2;

    localparam score_t      MATE_LIMIT = 18'sd99000;
    localparam score_wide_t WIDE_MAX   = 19'sd131071;
    localparam score_wide_t WIDE_MIN   = -19'sd131072;

    typedef struct packed {
        logic [MOVE_W-1:0]  move;
        logic [BOUND_W-1:0] bound;
        logic [DEPTH_W-1:0] depth;
        score_t             score;
    } payload_t;

    function automatic score_wide_t ply_wide(logic [PLY_W-1:0] ply);
        return $signed({{(SCORE_W+1-PLY_W){1'b0}}, ply});
    endfunction

    // Push mate scores away from zero, saturating to the score range.
    function automatic score_t mate_store(score_t s, logic [PLY_W-1:0] ply);
        score_wide_t w;
        w = {s[SCORE_W-1], s};
        if (s > MATE_LIMIT) begin
            w = w + ply_wide(ply);
            if (w > WIDE_MAX) begin
                w = WIDE_MAX;
            end
        end else if (s < -MATE_LIMIT) begin
            w = w - ply_wide(ply);
            if (w < WIDE_MIN) begin
                w = WIDE_MIN;
            end
        end
        return score_t'(w[SCORE_W-1:0]);
    endfunction

    // Pull mate scores back toward zero.
    function automatic score_t mate_probe(score_t s, logic [PLY_W-1:0] ply);
        score_wide_t w;
        w = {s[SCORE_W-1], s};
        if (s > MATE_LIMIT) begin
            w = w - ply_wide(ply);
        end else if (s < -MATE_LIMIT) begin
            w = w + ply_wide(ply);
        end
        return score_t'(w[SCORE_W-1:0]);
    endfunction

endpackage

`default_nettype wire

[rtl/core/hst_table.sv]
// Key, payload and valid memories with the post-reset valid clearing pass.
`default_nettype none

module hst_table (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      wr_en,
    input  wire logic                      rd_en,
    input  wire logic [hst_pkg::IDX_W-1:0] addr,
    input  wire logic [hst_pkg::KEY_W-1:0] wr_key,
    input  wire hst_pkg::payload_t         wr_payload,
    output logic [hst_pkg::KEY_W-1:0]      rd_key,
    output hst_pkg::payload_t              rd_payload,
    output logic                           rd_valid,
    output logic                           clr_busy
);
    import hst_pkg::*;

    logic [KEY_W-1:0] key_mem     [TABLE_ENTRIES];
    payload_t         payload_mem [TABLE_ENTRIES];
    logic             valid_mem   [TABLE_ENTRIES];

    logic             clr_busy_reg, clr_busy_next;
    logic [IDX_W-1:0] clr_idx_reg, clr_idx_next;
    logic [KEY_W-1:0] rd_key_reg;
    payload_t         rd_payload_reg;
    logic             rd_valid_reg;

    logic             vld_we;
    logic [IDX_W-1:0] vld_addr;

    always_comb begin
        clr_busy_next = clr_busy_reg;
        clr_idx_next  = clr_idx_reg;
        if (clr_busy_reg) begin
            clr_idx_next = clr_idx_reg + IDX_W'(1);
            if (clr_idx_reg == IDX_W'(TABLE_ENTRIES - 1)) begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end else begin
            clr_busy_reg <= clr_busy_next;
            clr_idx_reg  <= clr_idx_next;
        end
    end

    assign vld_we   = wr_en || clr_busy_reg;
    assign vld_addr = clr_busy_reg ? clr_idx_reg : addr;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            key_mem[addr]     <= wr_key;
            payload_mem[addr] <= wr_payload;
        end
        if (rd_en) begin
            rd_key_reg     <= key_mem[addr];
            rd_payload_reg <= payload_mem[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (vld_we) begin
            valid_mem[vld_addr] <= !clr_busy_reg;
        end
        if (rd_en) begin
            rd_valid_reg <= valid_mem[addr];
        end
    end

    assign rd_key     = rd_key_reg;
    assign rd_payload = rd_payload_reg;
    assign rd_valid   = rd_valid_reg;
    assign clr_busy   = clr_busy_reg;

endmodule

`default_nettype wire

[rtl/core/hst_eval.sv]
// Probe evaluation: key match, mate unshift, depth check and bound cutoff.
`default_nettype none

module hst_eval (
    input  wire logic [hst_pkg::KEY_W-1:0]   rd_key,
    input  wire hst_pkg::payload_t           rd_payload,
    input  wire logic                        rd_valid,
    input  wire logic [hst_pkg::KEY_W-1:0]   probe_key,
    input  wire logic [hst_pkg::DEPTH_W-1:0] probe_depth,
    input  wire logic [hst_pkg::PLY_W-1:0]   probe_ply,
    input  wire hst_pkg::score_t             probe_alpha,
    input  wire hst_pkg::score_t             probe_beta,
    output logic [hst_pkg::STATUS_W-1:0]     status,
    output hst_pkg::score_t                  score,
    output logic [hst_pkg::MOVE_W-1:0]       move
);
    import hst_pkg::*;

    logic   hit;
    logic   deep;
    score_t s_adj;

    assign hit   = rd_valid && (rd_key == probe_key);
    assign deep  = rd_payload.depth >= probe_depth;
    assign s_adj = mate_probe(rd_payload.score, probe_ply);

    always_comb begin
        status = ST_SHALLOW;
        score  = '0;
        move   = rd_payload.move;
        if (!hit) begin
            status = ST_MISS;
            move   = '0;
        end else if (deep) begin
            case (rd_payload.bound)
                BOUND_EXACT: begin
                    status = ST_USABLE;
                    score  = s_adj;
                end
                BOUND_UPPER: begin
                    if (s_adj <= probe_alpha) begin
                        status = ST_USABLE;
                        score  = probe_alpha;
                    end
                end
                BOUND_LOWER: begin
                    if (s_adj >= probe_beta) begin
                        status = ST_USABLE;
                        score  = probe_beta;
                    end
                end
                default: begin
                    status = ST_SHALLOW;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/core/hashed_score_table.sv]
// Top level of the hashed score table: request decode, probe stage and output register.
//
// Direct-mapped, always-replace score table, one entry per low-key-bits slot.
// Input channel s_*: s_tuser selects store (0) or probe (1); s_tdata carries
// key, depth, score, bound, move, ply and the alpha/beta window.
// Result channel m_*: one result per probe, none per store. m_tuser is the
// probe status; m_tdata holds the score and the stored move.
// A store is written in the cycle it is accepted. A probe reads the table
// at acceptance; the read stage then evaluates it into the output register
// when that register is free or being emptied, and the result leaves from there.
// One request is accepted per cycle while the result path flows, since
// every request touches the table through a single access at acceptance.
// After reset a clearing pass writes all TABLE_ENTRIES (4096) entries of the
// valid memory with s_tready low; no result is pending afterwards.
// When the receiver stalls, the result holds in the output register and
// one further probe may wait in the read stage; then s_tready drops.
`default_nettype none

module hashed_score_table (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // pos_key, search_depth, score_in, bound_kind, best_move, ply_from_root,
    // alpha_bound, beta_bound
    input  wire logic [hst_pkg::S_TDATA_W-1:0] s_tdata,
    // req_type
    input  wire logic [0:0]                    s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // score_out, stored_move, zero pad
    output logic [hst_pkg::M_TDATA_W-1:0]      m_tdata,
    // probe_status
    output logic [hst_pkg::STATUS_W-1:0]       m_tuser
);
    import hst_pkg::*;

    logic [KEY_W-1:0]   in_key;
    logic [DEPTH_W-1:0] in_depth;
    score_t             in_score;
    logic [BOUND_W-1:0] in_bound;
    logic [MOVE_W-1:0]  in_move;
    logic [PLY_W-1:0]   in_ply;
    score_t             in_alpha;
    score_t             in_beta;

    logic     accept;
    logic     wr_en;
    logic     rd_en;
    payload_t wr_payload;

    logic [KEY_W-1:0] rd_key;
    payload_t         rd_payload;
    logic             rd_valid;
    logic             clr_busy;

    logic               p1_valid_reg, p1_valid_next;
    logic [KEY_W-1:0]   p1_key_reg;
    logic [DEPTH_W-1:0] p1_depth_reg;
    logic [PLY_W-1:0]   p1_ply_reg;
    score_t             p1_alpha_reg;
    score_t             p1_beta_reg;
    logic               advance;

    logic [STATUS_W-1:0] ev_status;
    score_t              ev_score;
    logic [MOVE_W-1:0]   ev_move;

    logic                m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0] m_status_reg;
    score_t              m_score_reg;
    logic [MOVE_W-1:0]   m_move_reg;

    assign in_key   = s_tdata[63:0];
    assign in_depth = s_tdata[71:64];
    assign in_score = score_t'(s_tdata[89:72]);
    assign in_bound = s_tdata[91:90];
    assign in_move  = s_tdata[107:92];
    assign in_ply   = s_tdata[115:108];
    assign in_alpha = score_t'(s_tdata[133:116]);
    assign in_beta  = score_t'(s_tdata[151:134]);

    assign advance  = p1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !clr_busy && !(p1_valid_reg && !advance);
    assign accept   = s_tvalid && s_tready;
    assign wr_en    = accept && (s_tuser == REQ_STORE);
    assign rd_en    = accept && (s_tuser == REQ_PROBE);

    always_comb begin
        wr_payload.score = mate_store(in_score, in_ply);
        wr_payload.depth = in_depth;
        wr_payload.bound = in_bound;
        wr_payload.move  = in_move;
    end

    hst_table u_table (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .wr_en      (wr_en),
        .rd_en      (rd_en),
        .addr       (in_key[IDX_W-1:0]),
        .wr_key     (in_key),
        .wr_payload (wr_payload),
        .rd_key     (rd_key),
        .rd_payload (rd_payload),
        .rd_valid   (rd_valid),
        .clr_busy   (clr_busy)
    );

    hst_eval u_eval (
        .rd_key      (rd_key),
        .rd_payload  (rd_payload),
        .rd_valid    (rd_valid),
        .probe_key   (p1_key_reg),
        .probe_depth (p1_depth_reg),
        .probe_ply   (p1_ply_reg),
        .probe_alpha (p1_alpha_reg),
        .probe_beta  (p1_beta_reg),
        .status      (ev_status),
        .score       (ev_score),
        .move        (ev_move)
    );

    always_comb begin
        p1_valid_next = p1_valid_reg;
        if (rd_en) begin
            p1_valid_next = 1'b1;
        end else if (advance) begin
            p1_valid_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            p1_valid_reg <= p1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            p1_key_reg   <= in_key;
            p1_depth_reg <= in_depth;
            p1_ply_reg   <= in_ply;
            p1_alpha_reg <= in_alpha;
            p1_beta_reg  <= in_beta;
        end
        if (advance) begin
            m_status_reg <= ev_status;
            m_score_reg  <= ev_score;
            m_move_reg   <= ev_move;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {{(M_TDATA_W - SCORE_W - MOVE_W){1'b0}}, m_move_reg, m_score_reg};

endmodule

`default_nettype wire

[rtl/core/hst_checker.sv]
// Port-level assertions for the hashed score table, bound to the top level.
`default_nettype none

module hst_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic [hst_pkg::S_TDATA_W-1:0] s_tdata,
    input wire logic [0:0]                    s_tuser,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [hst_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic [hst_pkg::STATUS_W-1:0]  m_tuser
);
    import hst_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_MISS) |-> (m_tdata == '0))
        else $error("key miss with nonzero data");

    a_unusable_score: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != ST_USABLE) |-> (m_tdata[SCORE_W-1:0] == '0))
        else $error("unusable result with nonzero score");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !s_tready && !m_tvalid)
        else $error("activity right after reset");

    logic unused_in;
    assign unused_in = s_tvalid ^ (^s_tdata) ^ s_tuser[0];

endmodule

bind hashed_score_table hst_checker u_hst_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

[tb/hashed_score_table_tb.sv]
// Testbench for hashed_score_table: directed and random store/probe traffic with a predictor.
`default_nettype none

module hashed_score_table_tb;
    import hst_pkg::*;

    localparam int MATE_EDGE    = 99000;
    localparam int SCORE_TOP    = 131071;
    localparam int SCORE_BOTTOM = -131072;
    localparam logic [BOUND_W-1:0] BOUND_UNUSED = 2'd3;
    localparam logic [KEY_W-1:0]   KEY_ONES     = '1;
    localparam int POOL_SIZE    = 48;

    typedef struct {
        req_t              kind;
        logic [KEY_W-1:0]  key;
        logic [DEPTH_W-1:0] depth;
        int                score;
        logic [BOUND_W-1:0] bound;
        logic [MOVE_W-1:0] move;
        logic [PLY_W-1:0]  ply;
        int                alpha;
        int                beta;
    } request_t;

    typedef struct {
        bit                 valid;
        logic [KEY_W-1:0]   key;
        int                 score;
        logic [DEPTH_W-1:0] depth;
        logic [BOUND_W-1:0] bound;
        logic [MOVE_W-1:0]  move;
    } table_entry_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        int                  score;
        logic [MOVE_W-1:0]   move;
    } probe_result_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [0:0]           s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]  m_tuser;

    table_entry_t  score_table [TABLE_ENTRIES];
    probe_result_t pending_probe_results [$];
    logic [KEY_W-1:0] key_pool [POOL_SIZE];
    int mismatch_count = 0;
    int burst_left     = 0;
    int rx_left        = 0;
    int rx_mode        = 0;

    hashed_score_table u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #1 aclk = ~aclk;

    function automatic int clip_score(int s);
        if (s > SCORE_TOP) begin
            return SCORE_TOP;
        end
        if (s < SCORE_BOTTOM) begin
            return SCORE_BOTTOM;
        end
        return s;
    endfunction

    function automatic void record_store(request_t r);
        int s;
        s = r.score;
        if (s > MATE_EDGE) begin
            s = clip_score(s + int'(r.ply));
        end else if (s < -MATE_EDGE) begin
            s = clip_score(s - int'(r.ply));
        end
        score_table[r.key[IDX_W-1:0]] = '{1'b1, r.key, s, r.depth, r.bound, r.move};
    endfunction

    function automatic probe_result_t expected_probe(request_t r);
        table_entry_t  e;
        probe_result_t res;
        int            s;
        e = score_table[r.key[IDX_W-1:0]];
        res = '{ST_MISS, 0, '0};
        if (!e.valid || e.key != r.key) begin
            return res;
        end
        s = e.score;
        if (s > MATE_EDGE) begin
            s = s - int'(r.ply);
        end else if (s < -MATE_EDGE) begin
            s = s + int'(r.ply);
        end
        res = '{ST_SHALLOW, 0, e.move};
        if (e.depth >= r.depth) begin
            case (e.bound)
                BOUND_EXACT: begin
                    res.status = ST_USABLE;
                    res.score  = s;
                end
                BOUND_UPPER: begin
                    if (s <= r.alpha) begin
                        res.status = ST_USABLE;
                        res.score  = r.alpha;
                    end
                end
                BOUND_LOWER: begin
                    if (s >= r.beta) begin
                        res.status = ST_USABLE;
                        res.score  = r.beta;
                    end
                end
                default: ;
            endcase
        end
        return res;
    endfunction

    // Adjusted score a probe of this key would see, for steering alpha/beta.
    function automatic bit live_score(logic [KEY_W-1:0] key, logic [PLY_W-1:0] ply,
                                      output int s);
        table_entry_t e;
        e = score_table[key[IDX_W-1:0]];
        s = e.score;
        if (s > MATE_EDGE) begin
            s = s - int'(ply);
        end else if (s < -MATE_EDGE) begin
            s = s + int'(ply);
        end
        return e.valid && e.key == key;
    endfunction

    function automatic int rand_score_value();
        int pick;
        int mag;
        pick = $urandom_range(0, 9);
        if (pick < 3) begin
            mag = $urandom_range(MATE_EDGE + 1, SCORE_TOP);
            return $urandom_range(0, 1) ? mag : -mag;
        end
        if (pick == 3) begin
            case ($urandom_range(0, 5))
                0: return SCORE_TOP;
                1: return SCORE_BOTTOM;
                2: return MATE_EDGE;
                3: return -MATE_EDGE;
                4: return MATE_EDGE + 1;
                default: return -MATE_EDGE - 1;
            endcase
        end
        if (pick < 7) begin
            return int'($urandom_range(0, 4000)) - 2000;
        end
        return int'($urandom_range(0, 262143)) + SCORE_BOTTOM;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        mismatch_count++;
        $display("mismatch %s: got %0d, expected %0d", what, got, want);
    endtask

    // Sender: bursts of random length with random gaps between them.
    task automatic push_request(request_t r);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = $urandom_range(0, 1) ? $urandom_range(20, 80) : $urandom_range(1, 8);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= r.kind;
        s_tdata  <= {18'(r.beta), 18'(r.alpha), r.ply, r.move, r.bound, 18'(r.score),
                     r.depth, r.key};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (r.kind == REQ_STORE) begin
            record_store(r);
        end else begin
            pending_probe_results.push_back(expected_probe(r));
        end
    endtask

    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (pending_probe_results.size() != 0) @(posedge aclk);
    endtask

    task automatic store_item(logic [KEY_W-1:0] key, logic [DEPTH_W-1:0] depth, int score,
                              logic [BOUND_W-1:0] bound, logic [MOVE_W-1:0] move,
                              logic [PLY_W-1:0] ply);
        request_t r;
        r = '{REQ_STORE, key, depth, score, bound, move, ply,
              rand_score_value(), rand_score_value()};
        push_request(r);
    endtask

    task automatic probe_item(logic [KEY_W-1:0] key, logic [DEPTH_W-1:0] depth,
                              logic [PLY_W-1:0] ply, int alpha, int beta);
        request_t r;
        r = '{REQ_PROBE, key, depth, rand_score_value(), 2'($urandom_range(0, 3)),
              16'($urandom), ply, alpha, beta};
        push_request(r);
    endtask

    task automatic test_miss_on_empty();
        probe_item(64'h0123_4567_89AB_C000, 8'd0, 8'd0, 0, 0);
    endtask

    task automatic test_extremes();
        // saturating mate shifts at both ends of the score range
        store_item(KEY_ONES, 8'd255, SCORE_TOP, BOUND_EXACT, 16'hFFFF, 8'd200);
        probe_item(KEY_ONES, 8'd255, 8'd255, SCORE_BOTTOM, SCORE_TOP);
        store_item(64'h0, 8'd0, SCORE_BOTTOM, BOUND_EXACT, 16'h0000, 8'd255);
        probe_item(64'h0, 8'd0, 8'd10, SCORE_BOTTOM, SCORE_TOP);
    endtask

    task automatic test_slot_collision();
        probe_item(64'h7FFF_FFFF_FFFF_FFFF, 8'd0, 8'd0, 0, 0);
        store_item(64'h7FFF_FFFF_FFFF_FFFF, 8'd3, -1, BOUND_EXACT, 16'h1234, 8'd0);
        probe_item(KEY_ONES, 8'd0, 8'd0, 0, 0);
    endtask

    task automatic test_depth_gate();
        store_item(64'hA5A5_0000_0000_0101, 8'd5, 500, BOUND_EXACT, 16'hBEEF, 8'd7);
        probe_item(64'hA5A5_0000_0000_0101, 8'd5, 8'd7, 0, 0);
        probe_item(64'hA5A5_0000_0000_0101, 8'd6, 8'd7, 0, 0);
    endtask

    task automatic test_bound_cutoffs();
        store_item(64'h5A5A_1111_2222_0202, 8'd9, -300, BOUND_UPPER, 16'h0F0F, 8'd1);
        probe_item(64'h5A5A_1111_2222_0202, 8'd9, 8'd1, -200, 1000);
        probe_item(64'h5A5A_1111_2222_0202, 8'd9, 8'd1, -400, 1000);
        probe_item(64'h5A5A_1111_2222_0202, 8'd2, 8'd1, -300, 1000);
        store_item(64'h3C3C_4444_5555_0303, 8'd9, 700, BOUND_LOWER, 16'hF0F0, 8'd2);
        probe_item(64'h3C3C_4444_5555_0303, 8'd9, 8'd2, -1000, 600);
        probe_item(64'h3C3C_4444_5555_0303, 8'd9, 8'd2, -1000, 800);
        store_item(64'hC3C3_6666_7777_0404, 8'd9, 0, BOUND_UNUSED, 16'h5555, 8'd3);
        probe_item(64'hC3C3_6666_7777_0404, 8'd0, 8'd3, 100, -100);
    endtask

    task automatic test_mate_shift();
        // probe shift may carry a mate score back across the threshold
        store_item(64'h9999_8888_0000_0505, 8'd4, MATE_EDGE + 1, BOUND_EXACT, 16'h0001, 8'd0);
        probe_item(64'h9999_8888_0000_0505, 8'd4, 8'd5, 0, 0);
        store_item(64'h7777_6666_0000_0606, 8'd4, -MATE_EDGE - 1, BOUND_EXACT, 16'h8000,
                   8'd3);
        probe_item(64'h7777_6666_0000_0606, 8'd4, 8'd10, 0, 0);
        store_item(64'h1111_2222_0000_0707, 8'd4, MATE_EDGE, BOUND_EXACT, 16'h4242, 8'd50);
        probe_item(64'h1111_2222_0000_0707, 8'd4, 8'd50, 0, 0);
    endtask

    task automatic test_random_traffic(int count);
        request_t r;
        int       center;
        bit       hit;
        for (int i = 0; i < POOL_SIZE; i++) begin
            key_pool[i] = {$urandom, $urandom};
            if (i % 6 == 5) begin
                key_pool[i][IDX_W-1:0] = key_pool[i-1][IDX_W-1:0];
            end
        end
        for (int i = 0; i < count; i++) begin
            if (i == count / 2) begin
                wait_for_drain();
            end
            r.kind  = ($urandom_range(0, 99) < 45) ? REQ_STORE : REQ_PROBE;
            r.key   = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                                   : {$urandom, $urandom};
            r.depth = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 15)) : 8'($urandom);
            r.score = rand_score_value();
            case ($urandom_range(0, 9))
                0, 1, 2: r.bound = BOUND_EXACT;
                3, 4, 5: r.bound = BOUND_UPPER;
                6, 7, 8: r.bound = BOUND_LOWER;
                default: r.bound = BOUND_UNUSED;
            endcase
            r.move  = 16'($urandom);
            r.ply   = 8'($urandom);
            r.alpha = rand_score_value();
            r.beta  = rand_score_value();
            hit = live_score(r.key, r.ply, center);
            if (r.kind == REQ_PROBE && hit && $urandom_range(0, 9) < 7) begin
                r.alpha = clip_score(center + int'($urandom_range(0, 128)) - 64);
                r.beta  = clip_score(center + int'($urandom_range(0, 128)) - 64);
            end
            push_request(r);
        end
    endtask

    // Receiver: switches among steady, random, periodic and long-stall patterns.
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(20, 150);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2: m_tready <= (rx_left % 3 != 0);
            default: m_tready <= (rx_left % 14 < 2);
        endcase
    end

    always @(posedge aclk) begin : result_check
        probe_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_probe_results.size() == 0) begin
                report_mismatch("result with no probe pending", m_tuser, 0);
            end else begin
                want = pending_probe_results.pop_front();
                if (m_tuser !== want.status) begin
                    report_mismatch("probe_status", m_tuser, want.status);
                end
                if (m_tdata[SCORE_W-1:0] !== 18'(want.score)) begin
                    report_mismatch("score_out", $signed(m_tdata[SCORE_W-1:0]), want.score);
                end
                if (m_tdata[SCORE_W+MOVE_W-1:SCORE_W] !== want.move) begin
                    report_mismatch("stored_move", m_tdata[SCORE_W+MOVE_W-1:SCORE_W],
                                    want.move);
                end
            end
        end
    end

    initial begin
        #400000;
        $display("hashed_score_table verification failed");
        $finish;
    end

    initial begin
        aresetn <= 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_miss_on_empty();
        test_extremes();
        test_slot_collision();
        test_depth_gate();
        test_bound_cutoffs();
        test_mate_shift();
        test_random_traffic(1230);
        wait_for_drain();
        repeat (16) @(posedge aclk);
        if (mismatch_count == 0 && pending_probe_results.size() == 0) begin
            $display("hashed_score_table verification clean");
        end else begin
            $display("hashed_score_table verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
